@@ hdl/unsigned_shift_subtract_divider_defines.svh @@
// assertion macros for the unsigned shift-subtract divider
// used by the top level only, expects clk and rst_n in scope
`ifndef UNSIGNED_SHIFT_SUBTRACT_DIVIDER_DEFINES_SVH
`define UNSIGNED_SHIFT_SUBTRACT_DIVIDER_DEFINES_SVH

// same-cycle implication
`define USDIV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define USDIV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/usdiv_pkg.sv @@
// shared constants and types for the unsigned shift-subtract divider
// no dependencies
`default_nettype none

package usdiv_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] word_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } usdiv_cmd_t;

endpackage

`default_nettype wire

@@ hdl/usdiv_datapath.sv @@
// datapath of the divider: partial remainder, quotient shift register, result registers
// depends on usdiv_pkg
`default_nettype none

module usdiv_datapath
    import usdiv_pkg::*;
(
    input  wire logic       clk,
    input  wire usdiv_cmd_t cmd,
    input  wire word_t      dividend,
    input  wire word_t      divisor,
    output word_t           quotient,
    output word_t           remainder,
    output logic            div_by_zero
);

    word_t rem_reg;
    word_t quo_reg;
    word_t div_reg;
    logic  dz_reg;

    word_t quotient_reg;
    word_t remainder_reg;
    logic  div_by_zero_reg;

    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;
    logic             ge;
    word_t            rem_next;
    word_t            quo_next;

    // quo_reg holds the remaining dividend bits at the top and quotient bits at the bottom
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[WIDTH-1]};
        diff     = {1'b0, shifted} - {2'b00, div_reg};
        ge       = ~diff[WIDTH+1];
        rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
            dz_reg  <= (divisor == '0);
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end

        // a zero divisor runs through the same loop: all ones and the dividend fall out
        if (cmd.publish)
        begin
            quotient_reg    <= quo_next;
            remainder_reg   <= rem_next;
            div_by_zero_reg <= dz_reg;
        end
    end

    assign quotient    = quotient_reg;
    assign remainder   = remainder_reg;
    assign div_by_zero = div_by_zero_reg;

endmodule

`default_nettype wire

@@ hdl/usdiv_ctrl.sv @@
// controller of the divider: accepts a transaction, counts the bit steps, fires done
// depends on usdiv_pkg
`default_nettype none

module usdiv_ctrl
    import usdiv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    output logic       done,
    output usdiv_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic             last;

    assign last = (cnt_reg == CNT_W'(WIDTH - 1));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    busy_next  = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    cmd.publish = 1'b1;
                    done_next   = 1'b1;
                    busy_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ hdl/unsigned_shift_subtract_divider.sv @@
// Unsigned restoring divider, 32-bit operands. A transaction is taken when start is high
// and busy is low. The quotient takes one bit per clock from a single subtract-and-compare
// stage iterated once per quotient bit. done rises at the edge that ends the last step and is
// high for that one cycle only; quotient, remainder and div_by_zero are registered with it and
// hold until the next done. They are taken at the edge that ends that cycle. The receiver
// cannot stall and must capture them then. busy falls as done rises, so a new transaction can
// start in the done cycle. A zero divisor returns all ones as quotient and the dividend as
// remainder, with div_by_zero set.
// depends on usdiv_pkg, usdiv_ctrl, usdiv_datapath and the defines header
`default_nettype none

`include "unsigned_shift_subtract_divider_defines.svh"

module unsigned_shift_subtract_divider
    import usdiv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire word_t dividend,
    input  wire word_t divisor,
    output logic       done,
    output word_t      quotient,
    output word_t      remainder,
    output logic       div_by_zero
);

    usdiv_cmd_t cmd;

    usdiv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    usdiv_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .dividend    (dividend),
        .divisor     (divisor),
        .quotient    (quotient),
        .remainder   (remainder),
        .div_by_zero (div_by_zero)
    );

    `USDIV_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `USDIV_ASSERT_NEXT(a_done_single, done, !done, "done lasted more than one cycle")
    `USDIV_ASSERT_NOW(a_done_busy_fell, done, $fell(busy), "done without busy falling")
    `USDIV_ASSERT_NOW(a_dz_all_ones, done && div_by_zero, quotient == '1,
                      "divide by zero quotient not all ones")

endmodule

`default_nettype wire
